[sv/scp_pkg.sv]
package scp_pkg;

    // Coordinate width and the widths that follow from it.
    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int DOT_BITS   = PROD_BITS + 1;
    localparam int LEN_BITS   = PROD_BITS;
    localparam int QUO_BITS   = DIFF_BITS;
    localparam int REM_BITS   = LEN_BITS + QUO_BITS;

    // Where the projection falls on the segment.
    typedef enum logic [1:0] {
        REGION_START    = 2'd0,
        REGION_INTERIOR = 2'd1,
        REGION_END      = 2'd2
    } region_t;

    // Values that ride along with a word through the pipeline.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        region_t                      region;
        logic                         neg_x;
        logic                         neg_y;
    } side_t;

    // Word handed from one divider cell to the next.
    typedef struct packed {
        logic [REM_BITS-1:0] rem_x;
        logic [REM_BITS-1:0] rem_y;
        logic [LEN_BITS-1:0] den;
        logic [QUO_BITS-1:0] quo_x;
        logic [QUO_BITS-1:0] quo_y;
        side_t               side;
    } div_t;

endpackage

[sv/scp_in_if.sv]
interface scp_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [scp_pkg::COORD_BITS-1:0] start_x;
    logic signed [scp_pkg::COORD_BITS-1:0] start_y;
    logic signed [scp_pkg::COORD_BITS-1:0] end_x;
    logic signed [scp_pkg::COORD_BITS-1:0] end_y;
    logic signed [scp_pkg::COORD_BITS-1:0] point_x;
    logic signed [scp_pkg::COORD_BITS-1:0] point_y;

    modport source (
        output valid, start_x, start_y, end_x, end_y, point_x, point_y,
        input  ready
    );

    modport sink (
        input  valid, start_x, start_y, end_x, end_y, point_x, point_y,
        output ready
    );
endinterface

[sv/scp_out_if.sv]
interface scp_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [scp_pkg::COORD_BITS-1:0] near_x;
    logic signed [scp_pkg::COORD_BITS-1:0] near_y;
    logic [1:0]                          region;

    modport source (
        output valid, near_x, near_y, region,
        input  ready
    );

    modport sink (
        input  valid, near_x, near_y, region,
        output ready
    );
endinterface

[sv/scp_front.sv]
module scp_front (
    input  logic          clk,
    input  logic          rst_n,
    scp_in_if.sink        in_ch,
    output logic          dn_valid,
    output scp_pkg::div_t dn_data,
    input  logic          dn_ready
);

    typedef struct packed {
        logic signed [scp_pkg::DIFF_BITS-1:0] dx;
        logic signed [scp_pkg::DIFF_BITS-1:0] dy;
        logic signed [scp_pkg::DIFF_BITS-1:0] ex;
        logic signed [scp_pkg::DIFF_BITS-1:0] ey;
        scp_pkg::side_t                       side;
    } diff_t;

    typedef struct packed {
        logic signed [scp_pkg::PROD_BITS-1:0] pxx;
        logic signed [scp_pkg::PROD_BITS-1:0] pyy;
        logic signed [scp_pkg::PROD_BITS-1:0] lxx;
        logic signed [scp_pkg::PROD_BITS-1:0] lyy;
        logic signed [scp_pkg::DIFF_BITS-1:0] dx;
        logic signed [scp_pkg::DIFF_BITS-1:0] dy;
        scp_pkg::side_t                       side;
    } prod_t;

    typedef struct packed {
        logic signed [scp_pkg::DOT_BITS-1:0] dot;
        logic [scp_pkg::LEN_BITS-1:0]        len2;
        logic [scp_pkg::DIFF_BITS-1:0]       mag_x;
        logic [scp_pkg::DIFF_BITS-1:0]       mag_y;
        scp_pkg::side_t                      side;
    } sum_t;

    logic          v0_reg, v1_reg, v2_reg, v3_reg;
    logic          en0, en1, en2, en3;
    diff_t         s0_reg, s0_next;
    prod_t         s1_reg, s1_next;
    sum_t          s2_reg, s2_next;
    scp_pkg::div_t s3_reg, s3_next;
    logic [scp_pkg::LEN_BITS-1:0] dot_u;

    // Each stage loads when it is empty or its successor moves on.
    assign en3         = !v3_reg || dn_ready;
    assign en2         = !v2_reg || en3;
    assign en1         = !v1_reg || en2;
    assign en0         = !v0_reg || en1;
    assign in_ch.ready = en0;
    assign dn_valid    = v3_reg;
    assign dn_data     = s3_reg;

    // Stage 0: segment direction and offset of the query point.
    always_comb
    begin
        s0_next.dx = $signed({in_ch.end_x[scp_pkg::COORD_BITS-1], in_ch.end_x})
                   - $signed({in_ch.start_x[scp_pkg::COORD_BITS-1], in_ch.start_x});
        s0_next.dy = $signed({in_ch.end_y[scp_pkg::COORD_BITS-1], in_ch.end_y})
                   - $signed({in_ch.start_y[scp_pkg::COORD_BITS-1], in_ch.start_y});
        s0_next.ex = $signed({in_ch.point_x[scp_pkg::COORD_BITS-1], in_ch.point_x})
                   - $signed({in_ch.start_x[scp_pkg::COORD_BITS-1], in_ch.start_x});
        s0_next.ey = $signed({in_ch.point_y[scp_pkg::COORD_BITS-1], in_ch.point_y})
                   - $signed({in_ch.start_y[scp_pkg::COORD_BITS-1], in_ch.start_y});
        s0_next.side.start_x = in_ch.start_x;
        s0_next.side.start_y = in_ch.start_y;
        s0_next.side.end_x   = in_ch.end_x;
        s0_next.side.end_y   = in_ch.end_y;
        s0_next.side.region  = scp_pkg::REGION_START;
        s0_next.side.neg_x   = 1'b0;
        s0_next.side.neg_y   = 1'b0;
    end

    // Stage 1: the four exact products.
    always_comb
    begin
        s1_next.pxx  = s0_reg.dx * s0_reg.ex;
        s1_next.pyy  = s0_reg.dy * s0_reg.ey;
        s1_next.lxx  = s0_reg.dx * s0_reg.dx;
        s1_next.lyy  = s0_reg.dy * s0_reg.dy;
        s1_next.dx   = s0_reg.dx;
        s1_next.dy   = s0_reg.dy;
        s1_next.side = s0_reg.side;
    end

    // Stage 2: dot product, squared length and direction magnitudes.
    always_comb
    begin
        s2_next.dot  = $signed({s1_reg.pxx[scp_pkg::PROD_BITS-1], s1_reg.pxx})
                     + $signed({s1_reg.pyy[scp_pkg::PROD_BITS-1], s1_reg.pyy});
        s2_next.len2 = s1_reg.lxx[scp_pkg::LEN_BITS-1:0] + s1_reg.lyy[scp_pkg::LEN_BITS-1:0];
        s2_next.mag_x = s1_reg.dx[scp_pkg::DIFF_BITS-1] ? scp_pkg::DIFF_BITS'(-s1_reg.dx)
                                                        : scp_pkg::DIFF_BITS'(s1_reg.dx);
        s2_next.mag_y = s1_reg.dy[scp_pkg::DIFF_BITS-1] ? scp_pkg::DIFF_BITS'(-s1_reg.dy)
                                                        : scp_pkg::DIFF_BITS'(s1_reg.dy);
        s2_next.side       = s1_reg.side;
        s2_next.side.neg_x = s1_reg.dx[scp_pkg::DIFF_BITS-1];
        s2_next.side.neg_y = s1_reg.dy[scp_pkg::DIFF_BITS-1];
    end

    // Stage 3: classify the projection and form the dividends.
    always_comb
    begin
        dot_u = s2_reg.dot[scp_pkg::LEN_BITS-1:0];
        s3_next.side = s2_reg.side;
        if (s2_reg.dot[scp_pkg::DOT_BITS-1] || (s2_reg.dot == '0))
        begin
            s3_next.side.region = scp_pkg::REGION_START;
        end
        else if (dot_u >= s2_reg.len2)
        begin
            s3_next.side.region = scp_pkg::REGION_END;
        end
        else
        begin
            s3_next.side.region = scp_pkg::REGION_INTERIOR;
        end
        s3_next.rem_x = s2_reg.mag_x * dot_u;
        s3_next.rem_y = s2_reg.mag_y * dot_u;
        s3_next.den   = s2_reg.len2;
        s3_next.quo_x = '0;
        s3_next.quo_y = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en0) v0_reg <= in_ch.valid;
            if (en1) v1_reg <= v0_reg;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0 && in_ch.valid) s0_reg <= s0_next;
        if (en1 && v0_reg)      s1_reg <= s1_next;
        if (en2 && v1_reg)      s2_reg <= s2_next;
        if (en3 && v2_reg)      s3_reg <= s3_next;
    end

endmodule

[sv/scp_div_cell.sv]
module scp_div_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    input  scp_pkg::div_t up_data,
    output logic          up_ready,
    output logic          dn_valid,
    output scp_pkg::div_t dn_data,
    input  logic          dn_ready
);

    logic                         v_reg;
    scp_pkg::div_t                d_reg, d_next;
    logic [scp_pkg::REM_BITS-1:0] cmp;
    logic [scp_pkg::REM_BITS-1:0] diff_x, diff_y;
    logic                         bit_x, bit_y;

    assign up_ready = !v_reg || dn_ready;
    assign dn_valid = v_reg;
    assign dn_data  = d_reg;

    // One restoring step per axis: the divisor sits at the top quotient
    // position and the remainder shifts left past it.
    always_comb
    begin
        cmp    = {1'b0, up_data.den, {(scp_pkg::QUO_BITS-1){1'b0}}};
        bit_x  = up_data.rem_x >= cmp;
        bit_y  = up_data.rem_y >= cmp;
        diff_x = bit_x ? up_data.rem_x - cmp : up_data.rem_x;
        diff_y = bit_y ? up_data.rem_y - cmp : up_data.rem_y;
        d_next       = up_data;
        d_next.rem_x = {diff_x[scp_pkg::REM_BITS-2:0], 1'b0};
        d_next.rem_y = {diff_y[scp_pkg::REM_BITS-2:0], 1'b0};
        d_next.quo_x = {up_data.quo_x[scp_pkg::QUO_BITS-2:0], bit_x};
        d_next.quo_y = {up_data.quo_y[scp_pkg::QUO_BITS-2:0], bit_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            d_reg <= d_next;
        end
    end

endmodule

[sv/scp_back.sv]
module scp_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    input  scp_pkg::div_t up_data,
    output logic          up_ready,
    scp_out_if.source     out_ch
);

    logic                                  v_reg;
    logic signed [scp_pkg::COORD_BITS-1:0] near_x_reg, near_x_next;
    logic signed [scp_pkg::COORD_BITS-1:0] near_y_reg, near_y_next;
    scp_pkg::region_t                      region_reg;
    logic [scp_pkg::COORD_BITS-1:0]        qx, qy;

    assign up_ready      = !v_reg || out_ch.ready;
    assign out_ch.valid  = v_reg;
    assign out_ch.near_x = near_x_reg;
    assign out_ch.near_y = near_y_reg;
    assign out_ch.region = region_reg;

    // Pick the clamped end point or add the signed scaled offset.
    // The interior quotient is below the direction magnitude, so it fits
    // a coordinate and the sum wraps to the exact result.
    always_comb
    begin
        qx = up_data.quo_x[scp_pkg::COORD_BITS-1:0];
        qy = up_data.quo_y[scp_pkg::COORD_BITS-1:0];
        case (up_data.side.region)
            scp_pkg::REGION_INTERIOR:
            begin
                near_x_next = up_data.side.start_x + (up_data.side.neg_x ? -qx : qx);
                near_y_next = up_data.side.start_y + (up_data.side.neg_y ? -qy : qy);
            end
            scp_pkg::REGION_END:
            begin
                near_x_next = up_data.side.end_x;
                near_y_next = up_data.side.end_y;
            end
            default:
            begin
                near_x_next = up_data.side.start_x;
                near_y_next = up_data.side.start_y;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            near_x_reg <= near_x_next;
            near_y_reg <= near_y_next;
            region_reg <= up_data.side.region;
        end
    end

endmodule

[sv/segment_closest_point.sv]
// Channel   Role    Word
// in_ch     sink    start_x, start_y, end_x, end_y, point_x, point_y
// out_ch    source  near_x, near_y, region
//
// One word is accepted per cycle while the output is not stalled, and each gives one result word in order.
// The pipeline is four arithmetic stages, one divider cell
// per quotient bit (COORD_BITS + 1 of them), and the output register.
// Every stage has its own valid bit and loads whenever it is empty or its
// successor moves on, so a stalled output only fills the empty stages behind it.
// Reset (rst_n, asynchronous, active low) empties every stage.
module segment_closest_point (
    input  logic      clk,
    input  logic      rst_n,
    scp_in_if.sink    in_ch,
    scp_out_if.source out_ch
);

    localparam int NCELL = scp_pkg::QUO_BITS;

    logic          valid_c [NCELL+1];
    logic          ready_c [NCELL+1];
    scp_pkg::div_t data_c  [NCELL+1];

    // Operand stages: differences, products, sums and dividends.
    scp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .dn_valid (valid_c[0]),
        .dn_data  (data_c[0]),
        .dn_ready (ready_c[0])
    );

    // Row of divider cells, one quotient bit each.
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        scp_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (valid_c[i]),
            .up_data  (data_c[i]),
            .up_ready (ready_c[i]),
            .dn_valid (valid_c[i+1]),
            .dn_data  (data_c[i+1]),
            .dn_ready (ready_c[i+1])
        );
    end

    // Result assembly and output register.
    scp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (valid_c[NCELL]),
        .up_data  (data_c[NCELL]),
        .up_ready (ready_c[NCELL]),
        .out_ch   (out_ch)
    );

endmodule

[dv/scp_checker.sv]
module scp_checker (
    input  logic clk,
    input  logic rst_n,
    scp_in_if    in_ch,
    scp_out_if   out_ch,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [scp_pkg::COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t           near_x;
        coord_t           near_y;
        scp_pkg::region_t region;
    } nearest_t;

    // Results still owed by the block, oldest at the front.
    nearest_t awaited_points[$];

    int error_count   = 0;
    int awaited_count = 0;

    assign errors  = error_count;
    assign pending = awaited_count;

    // Project the query point onto the segment and clamp to its ends.
    // Products stay far below 64 bits, and signed division truncates toward zero.
    function automatic nearest_t nearest_on_segment(input coord_t sx, input coord_t sy,
                                                    input coord_t ex, input coord_t ey,
                                                    input coord_t px, input coord_t py);
        longint dx;
        longint dy;
        longint dot;
        longint len2;
        longint rx;
        longint ry;
        nearest_t res;
        dx  = longint'(ex) - longint'(sx);
        dy  = longint'(ey) - longint'(sy);
        dot = dx * (longint'(px) - longint'(sx)) + dy * (longint'(py) - longint'(sy));
        len2 = dx * dx + dy * dy;
        if (dot <= 0) begin
            res.near_x = sx;
            res.near_y = sy;
            res.region = scp_pkg::REGION_START;
        end
        else if (dot >= len2) begin
            res.near_x = ex;
            res.near_y = ey;
            res.region = scp_pkg::REGION_END;
        end
        else begin
            rx = longint'(sx) + (dx * dot) / len2;
            ry = longint'(sy) + (dy * dot) / len2;
            res.near_x = rx[scp_pkg::COORD_BITS-1:0];
            res.near_y = ry[scp_pkg::COORD_BITS-1:0];
            res.region = scp_pkg::REGION_INTERIOR;
        end
        return res;
    endfunction

    // Record each accepted input word and check each accepted output word.
    always @(posedge clk)
    begin : watch
        nearest_t want;
        int       bad;
        bad = 0;
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                awaited_points.push_back(nearest_on_segment(in_ch.start_x, in_ch.start_y,
                                                            in_ch.end_x, in_ch.end_y,
                                                            in_ch.point_x, in_ch.point_y));
            end
            if (out_ch.valid && out_ch.ready) begin
                if (awaited_points.size() == 0) begin
                    $display("%0t: output word with nothing awaited: near=(%0d,%0d) region=%0d",
                             $time, out_ch.near_x, out_ch.near_y, out_ch.region);
                    bad = bad + 1;
                end
                else begin
                    want = awaited_points.pop_front();
                    if (out_ch.near_x !== want.near_x) begin
                        $display("%0t: near_x expected %0d, got %0d",
                                 $time, want.near_x, out_ch.near_x);
                        bad = bad + 1;
                    end
                    if (out_ch.near_y !== want.near_y) begin
                        $display("%0t: near_y expected %0d, got %0d",
                                 $time, want.near_y, out_ch.near_y);
                        bad = bad + 1;
                    end
                    if (out_ch.region !== want.region) begin
                        $display("%0t: region expected %0d, got %0d",
                                 $time, want.region, out_ch.region);
                        bad = bad + 1;
                    end
                end
            end
        end
        error_count   <= error_count + bad;
        awaited_count <= awaited_points.size();
    end
endmodule

[dv/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     LATENCY      = scp_pkg::COORD_BITS + 6;
    localparam int     RANDOM_WORDS = 1950;
    localparam int     IDLE_PCT     = 17;
    localparam longint CYCLE_LIMIT  = 400000;

    typedef logic signed [scp_pkg::COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        coord_t px;
        coord_t py;
    } query_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    bit     calm = 1'b0;
    int     errors;
    int     pending;
    longint cycles = 0;

    scp_in_if  in_ch ();
    scp_out_if out_ch ();

    segment_closest_point dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    scp_checker u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .errors  (errors),
        .pending (pending)
    );

    always #1 clk = ~clk;

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // The receiver stalls at random unless a calm stretch is running.
    always @(negedge clk)
    begin
        out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic query_t mk(input int sx, input int sy, input int ex,
                                  input int ey, input int px, input int py);
        query_t q;
        q.sx = coord_t'(sx);
        q.sy = coord_t'(sy);
        q.ex = coord_t'(ex);
        q.ey = coord_t'(ey);
        q.px = coord_t'(px);
        q.py = coord_t'(py);
        return q;
    endfunction

    function automatic int span(input int lim);
        return int'($urandom_range(2 * lim)) - lim;
    endfunction

    function automatic int edge_coord();
        case ($urandom_range(5))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return -1;
            4:       return 1;
            default: return int'($urandom);
        endcase
    endfunction

    // Random query shapes: wide noise, small geometry, degenerate segments,
    // points exactly abreast of either end, corner values, and points scattered near the start.
    function automatic query_t make_query();
        int     sxi;
        int     syi;
        int     dxi;
        int     dyi;
        int     t;
        bit     at_end;
        query_t q;
        sxi    = span(2000);
        syi    = span(2000);
        dxi    = span(2000);
        dyi    = span(2000);
        t      = span(8);
        at_end = ($urandom_range(1) != 0);
        case ($urandom_range(9))
            0, 1, 2: q = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            3, 4:    q = mk(span(64), span(64), span(64), span(64), span(96), span(96));
            5:       q = mk(sxi, syi, sxi, syi, $urandom, $urandom);
            6, 7: begin
                if (at_end)
                    q = mk(sxi, syi, sxi + dxi, syi + dyi,
                           sxi + dxi - t * dyi, syi + dyi + t * dxi);
                else
                    q = mk(sxi, syi, sxi + dxi, syi + dyi, sxi - t * dyi, syi + t * dxi);
            end
            8:       q = mk(edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                            edge_coord(), edge_coord());
            default: q = mk(sxi, syi, sxi + dxi, syi + dyi,
                            sxi + span(3000), syi + span(3000));
        endcase
        return q;
    endfunction

    // Present one word and hold it until the block takes it.
    task automatic send(input query_t q);
        @(negedge clk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.start_x <= q.sx;
        in_ch.start_y <= q.sy;
        in_ch.end_x   <= q.ex;
        in_ch.end_y   <= q.ey;
        in_ch.point_x <= q.px;
        in_ch.point_y <= q.py;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Drop valid and wait until every awaited result has come back.
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial
    begin
        in_ch.valid   = 1'b0;
        in_ch.start_x = '0;
        in_ch.start_y = '0;
        in_ch.end_x   = '0;
        in_ch.end_y   = '0;
        in_ch.point_x = '0;
        in_ch.point_y = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words: extremes, each region, and the exact boundaries.
        send(mk(0, 0, 0, 0, 0, 0));
        send(mk(-32768, -32768, -32768, -32768, 32767, 32767));
        send(mk(32767, 32767, 32767, 32767, -32768, -32768));
        send(mk(-32768, -32768, 32767, 32767, -32768, -32768));
        send(mk(-32768, -32768, 32767, 32767, 32767, 32767));
        send(mk(-32768, -32768, 32767, 32767, 32767, -32768));
        send(mk(-32768, -32768, 32767, 32767, 0, 0));
        send(mk(32767, -32768, -32768, 32767, 32767, 32767));
        send(mk(32767, 32767, -32768, -32768, -32768, -32768));
        send(mk(-32768, 32767, 32767, -32768, 100, -200));
        send(mk(0, 0, 3, 4, 7, 1));
        send(mk(0, 0, 3, 4, -4, 3));
        send(mk(0, 0, 3, 4, 1, 1));
        send(mk(0, 0, -3, -7, -1, -1));
        send(mk(5, -5, -7, 3, 0, 0));
        send(mk(10, 10, 20, 10, 15, 32767));
        send(mk(10, 10, 20, 10, 15, -32768));
        send(mk(-1, -1, 1, 1, 32767, -32768));
        send(mk(100, 100, 100, 100, 100, 100));
        send(mk(0, 0, 32767, 0, 32766, 5));
        send(mk(0, 0, -32768, 1, -32767, 0));
        drain();

        // Random words, with one calm stretch and one full pause.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            calm = (i >= 600 && i < 900);
            if (i == 1300)
                drain();
            send(make_query());
        end
        calm = 1'b0;

        drain();
        repeat (LATENCY + 8) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

[segment_closest_point.f]
sv/scp_pkg.sv
sv/scp_in_if.sv
sv/scp_out_if.sv
sv/scp_front.sv
sv/scp_div_cell.sv
sv/scp_back.sv
sv/segment_closest_point.sv
dv/scp_checker.sv
dv/testbench.sv
